// File: src/icmp_ep_pkg.sv
// Shared types, codes and helper function of the ICMP echo packet parser.
package icmp_ep_pkg;

   // Result status codes.
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_SHORT_IP   = 3'd1;
   localparam logic [2:0] ST_SHORT_ICMP = 3'd2;
   localparam logic [2:0] ST_BAD_SUM    = 3'd3;
   localparam logic [2:0] ST_BAD_TYPE   = 3'd4;

   // Where a byte sits within the packet, as found by the front part.
   localparam logic [2:0] KIND_NONE    = 3'd0;
   localparam logic [2:0] KIND_TYPE    = 3'd1;
   localparam logic [2:0] KIND_OTHER   = 3'd2;
   localparam logic [2:0] KIND_ID_HI   = 3'd3;
   localparam logic [2:0] KIND_ID_LO   = 3'd4;
   localparam logic [2:0] KIND_SQ_HI   = 3'd5;
   localparam logic [2:0] KIND_SQ_LO   = 3'd6;
   localparam logic [2:0] KIND_PAYLOAD = 3'd7;

   // ICMP type values for echo request and echo reply.
   localparam logic [7:0] TYPE_V4_REQ = 8'd8;
   localparam logic [7:0] TYPE_V4_REP = 8'd0;
   localparam logic [7:0] TYPE_V6_REQ = 8'd128;
   localparam logic [7:0] TYPE_V6_REP = 8'd129;

   localparam logic [15:0] ICMP_HDR_BYTES = 16'd8;
   localparam logic [15:0] SUM_GOOD       = 16'hffff;
   localparam logic [15:0] COUNT_MAX      = 16'hffff;

   // One classified item as it travels from the front part to the back part.
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        last_byte;
      logic [2:0]  kind;
      logic [2:0]  pre_status;
      logic [15:0] pay_len;
   } item_type;

   // One's-complement add with end-around carry.
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, w};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// File: src/icmp_ep_front.sv
// Front part: counts bytes, skips the IP header and classifies each item.
module icmp_ep_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,
   input  logic                  req_tlast,
   input  logic                  q_full,
   output logic                  q_push,
   output icmp_ep_pkg::item_type q_item,
   output logic                  mode
);

   logic        mode_ff, mode_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [5:0]  hdr_len_ff, hdr_len_in;

   logic [5:0]  hdr_cur;
   logic [15:0] hdr_wide;
   logic        in_icmp;
   logic [15:0] off;
   logic [15:0] total;
   logic [15:0] icmp_len;
   logic [2:0]  kind;
   logic [2:0]  pre_status;

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;
   assign mode       = mode_ff;

   // Header length is fixed on the first byte by the mode at that time.
   always_comb begin
      if (byte_count_ff == 16'd0) begin
         hdr_cur = mode_ff ? 6'd0 : {req_tdata[3:0], 2'b00};
      end else begin
         hdr_cur = hdr_len_ff;
      end
      hdr_wide = {10'd0, hdr_cur};
      in_icmp  = byte_count_ff >= hdr_wide;
      off      = byte_count_ff - hdr_wide;
      total    = (byte_count_ff == icmp_ep_pkg::COUNT_MAX) ? icmp_ep_pkg::COUNT_MAX
                                                           : byte_count_ff + 16'd1;
      icmp_len = total - hdr_wide;
   end

   // Position of the byte within the ICMP part.
   always_comb begin
      if (!in_icmp) begin
         kind = icmp_ep_pkg::KIND_NONE;
      end else if (off >= icmp_ep_pkg::ICMP_HDR_BYTES) begin
         kind = icmp_ep_pkg::KIND_PAYLOAD;
      end else begin
         case (off[2:0])
            3'd0:    kind = icmp_ep_pkg::KIND_TYPE;
            3'd4:    kind = icmp_ep_pkg::KIND_ID_HI;
            3'd5:    kind = icmp_ep_pkg::KIND_ID_LO;
            3'd6:    kind = icmp_ep_pkg::KIND_SQ_HI;
            3'd7:    kind = icmp_ep_pkg::KIND_SQ_LO;
            default: kind = icmp_ep_pkg::KIND_OTHER;
         endcase
      end
   end

   // Length checks that only depend on the byte count.
   always_comb begin
      if (total < hdr_wide) begin
         pre_status = icmp_ep_pkg::ST_SHORT_IP;
      end else if (icmp_len < icmp_ep_pkg::ICMP_HDR_BYTES) begin
         pre_status = icmp_ep_pkg::ST_SHORT_ICMP;
      end else begin
         pre_status = icmp_ep_pkg::ST_OK;
      end
   end

   always_comb begin
      q_item.data_byte  = req_tdata;
      q_item.last_byte  = req_tlast;
      q_item.kind       = kind;
      q_item.pre_status = pre_status;
      q_item.pay_len    = icmp_len - icmp_ep_pkg::ICMP_HDR_BYTES;
   end

   // Next state of the counters and the mode register.
   always_comb begin
      mode_in       = csr_wr_en ? csr_wr_data : mode_ff;
      byte_count_in = byte_count_ff;
      hdr_len_in    = hdr_len_ff;
      if (q_push) begin
         byte_count_in = req_tlast ? 16'd0 : total;
         hdr_len_in    = req_tlast ? 6'd0 : hdr_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= 1'b0;
         byte_count_ff <= 16'd0;
         hdr_len_ff    <= 6'd0;
      end else begin
         mode_ff       <= mode_in;
         byte_count_ff <= byte_count_in;
         hdr_len_ff    <= hdr_len_in;
      end
   end

endmodule

// File: src/icmp_ep_queue.sv
// Short queue of classified items between the front and back parts.
module icmp_ep_queue #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  icmp_ep_pkg::item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output icmp_ep_pkg::item_type head_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   icmp_ep_pkg::item_type slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Item storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: src/icmp_ep_back.sv
// Back part: checksum, field capture, final checks and the result register.
module icmp_ep_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  mode,
   input  logic                  q_valid,
   input  icmp_ep_pkg::item_type q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   logic [15:0] sum_ff, sum_in;
   logic [7:0]  pend_ff, pend_in;
   logic        odd_ff, odd_in;
   logic [7:0]  type_ff, type_in;
   logic [15:0] ident_ff, ident_in;
   logic [15:0] seqno_ff, seqno_in;

   logic        out_valid_ff, out_valid_in;
   logic        pv_ff, pv_in;
   logic [7:0]  pb_ff, pb_in;
   logic        done_ff, done_in;
   logic [2:0]  st_ff, st_in;
   logic        rep_ff, rep_in;
   logic [15:0] id_ff, id_in;
   logic [15:0] sq_ff, sq_in;
   logic [15:0] plen_ff, plen_in;

   logic        in_icmp;
   logic [15:0] word;
   logic [15:0] pair_sum;
   logic [15:0] final_sum;
   logic [7:0]  type_rq;
   logic [7:0]  type_rp;

   assign q_pop = q_valid && (!out_valid_ff || rsp_tready);

   // One adder serves both the pair update and the final padded sum.
   always_comb begin
      in_icmp   = q_item.kind != icmp_ep_pkg::KIND_NONE;
      word      = odd_ff ? {pend_ff, q_item.data_byte} : {q_item.data_byte, 8'd0};
      pair_sum  = icmp_ep_pkg::ones_add(sum_ff, word);
      final_sum = in_icmp ? pair_sum : sum_ff;
      type_rq   = mode ? icmp_ep_pkg::TYPE_V6_REQ : icmp_ep_pkg::TYPE_V4_REQ;
      type_rp   = mode ? icmp_ep_pkg::TYPE_V6_REP : icmp_ep_pkg::TYPE_V4_REP;
   end

   // Running packet state.
   always_comb begin
      sum_in   = sum_ff;
      pend_in  = pend_ff;
      odd_in   = odd_ff;
      type_in  = type_ff;
      ident_in = ident_ff;
      seqno_in = seqno_ff;
      if (q_pop) begin
         if (q_item.last_byte) begin
            sum_in   = 16'd0;
            pend_in  = 8'd0;
            odd_in   = 1'b0;
            type_in  = 8'd0;
            ident_in = 16'd0;
            seqno_in = 16'd0;
         end else begin
            if (in_icmp) begin
               if (odd_ff) begin
                  sum_in = pair_sum;
                  odd_in = 1'b0;
               end else begin
                  pend_in = q_item.data_byte;
                  odd_in  = 1'b1;
               end
            end
            case (q_item.kind)
               icmp_ep_pkg::KIND_TYPE:  type_in = q_item.data_byte;
               icmp_ep_pkg::KIND_ID_HI: ident_in[15:8] = q_item.data_byte;
               icmp_ep_pkg::KIND_ID_LO: ident_in[7:0] = q_item.data_byte;
               icmp_ep_pkg::KIND_SQ_HI: seqno_in[15:8] = q_item.data_byte;
               icmp_ep_pkg::KIND_SQ_LO: seqno_in[7:0] = q_item.data_byte;
               default: ;
            endcase
         end
      end
   end

   // Result for the item at the head of the queue.
   always_comb begin
      out_valid_in = out_valid_ff;
      pv_in        = pv_ff;
      pb_in        = pb_ff;
      done_in      = done_ff;
      st_in        = st_ff;
      rep_in       = rep_ff;
      id_in        = id_ff;
      sq_in        = sq_ff;
      plen_in      = plen_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
         pv_in        = q_item.kind == icmp_ep_pkg::KIND_PAYLOAD;
         pb_in        = pv_in ? q_item.data_byte : 8'd0;
         done_in      = q_item.last_byte;
         st_in        = icmp_ep_pkg::ST_OK;
         rep_in       = 1'b0;
         id_in        = 16'd0;
         sq_in        = 16'd0;
         plen_in      = 16'd0;
         if (q_item.last_byte) begin
            if (q_item.pre_status != icmp_ep_pkg::ST_OK) begin
               st_in = q_item.pre_status;
            end else if (!mode && final_sum != icmp_ep_pkg::SUM_GOOD) begin
               st_in = icmp_ep_pkg::ST_BAD_SUM;
            end else if (type_ff != type_rq && type_ff != type_rp) begin
               st_in = icmp_ep_pkg::ST_BAD_TYPE;
            end else begin
               rep_in  = type_ff == type_rp;
               id_in   = ident_ff;
               // A packet of exactly the ICMP header ends on the low sequence byte.
               sq_in   = (q_item.kind == icmp_ep_pkg::KIND_SQ_LO) ?
                         {seqno_ff[15:8], q_item.data_byte} : seqno_ff;
               plen_in = q_item.pay_len;
            end
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 16'd0;
         pend_ff      <= 8'd0;
         odd_ff       <= 1'b0;
         type_ff      <= 8'd0;
         ident_ff     <= 16'd0;
         seqno_ff     <= 16'd0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         pend_ff      <= pend_in;
         odd_ff       <= odd_in;
         type_ff      <= type_in;
         ident_ff     <= ident_in;
         seqno_ff     <= seqno_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      pv_ff   <= pv_in;
      pb_ff   <= pb_in;
      done_ff <= done_in;
      st_ff   <= st_in;
      rep_ff  <= rep_in;
      id_ff   <= id_in;
      sq_ff   <= sq_in;
      plen_ff <= plen_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = done_ff;
   assign rsp_tuser  = {rep_ff, pv_ff};
   assign rsp_tdata  = {5'd0, plen_ff, sq_ff, id_ff, st_ff, pb_ff};

   // Summary fields stay clear on results that do not end a packet.
   a_summary_only_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (st_ff == icmp_ep_pkg::ST_OK && !rep_ff &&
                                      id_ff == 16'd0 && sq_ff == 16'd0 && plen_ff == 16'd0))
      else $error("summary fields set on a result that does not end a packet");

   // A failed packet reports no echo details.
   a_fail_clears_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && st_ff != icmp_ep_pkg::ST_OK) |->
         (!rep_ff && id_ff == 16'd0 && sq_ff == 16'd0 && plen_ff == 16'd0))
      else $error("echo details reported on a failed packet");

   // Packet state is back at rest after the last item has been taken.
   a_state_clears_after_last: assert property (@(posedge clock) disable iff (reset)
      (q_pop && q_item.last_byte) |=> (sum_ff == 16'd0 && !odd_ff && type_ff == 8'd0))
      else $error("packet state not cleared after the last item");

   // The payload byte reads as zero whenever it is not flagged.
   a_payload_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !pv_ff) |-> pb_ff == 8'd0)
      else $error("payload byte set without its valid flag");

endmodule

// File: src/icmp_echo_packet_parser_top.sv
// Top level of the ICMP echo packet parser.
//
// The req_ channel takes a received packet one byte per item, with req_tlast
// on the final byte. Every accepted item gives exactly one item on the rsp_
// channel: payload bytes (after the 8-byte ICMP header) are flagged in
// rsp_tuser[0], and the item of the final byte carries rsp_tlast with the
// status, echo kind, identifier, sequence number and payload length.
// csr_wr_en / csr_wr_data select IPv4 (0: header skip and checksum check)
// or IPv6 (1: neither); write only while no packet is in flight.
// A byte is classified in the cycle it is accepted, queued, and its result is
// registered when the back part takes it from the queue. Throughput is one
// item per clock while rsp_tready stays high, set by the single one's
// complement adder in the back part that handles one byte per cycle.
// When rsp_tready is low the result register holds; the queue keeps
// accepting until it is full, then req_tready drops.
// Synchronous reset clears the mode to IPv4, empties the queue and the result
// register and clears all packet state.
module icmp_echo_packet_parser_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,    // ip_version_mode
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,      // [7:0] data_byte
   input  logic        req_tlast,      // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] payload_byte, [10:8] status, [26:11] ident, [42:27] seqno,
   // [58:43] payload length, [63:59] zero
   output logic [63:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,      // [0] payload_valid, [1] is_reply
   output logic        rsp_tlast       // done_res
);

   icmp_ep_pkg::item_type push_item;
   icmp_ep_pkg::item_type head_item;
   logic                  push;
   logic                  full;
   logic                  pop;
   logic                  head_valid;
   logic                  mode;

   icmp_ep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .q_full      (full),
      .q_push      (push),
      .q_item      (push_item),
      .mode        (mode)
   );

   icmp_ep_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   icmp_ep_back u_back (
      .clock      (clock),
      .reset      (reset),
      .mode       (mode),
      .q_valid    (head_valid),
      .q_item     (head_item),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: dv/icmp_echo_packet_parser_top_tb.sv
// Self-checking testbench for the ICMP echo packet parser: directed table, then random packets.
module icmp_echo_packet_parser_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic MODE_IPV4 = 1'b0;
   localparam logic MODE_IPV6 = 1'b1;
   localparam int RANDOM_ITEMS  = 1000;
   localparam int CYCLE_LIMIT   = 2000000;
   localparam int DRAIN_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 6;
   localparam int MAX_REPORTS   = 10;

   // One result item, as the parser should produce it.
   typedef struct packed {
      logic        pay_valid;
      logic [7:0]  pay_byte;
      logic        done;
      logic [2:0]  status;
      logic        reply;
      logic [15:0] ident;
      logic [15:0] seqno;
      logic [15:0] pay_len;
   } echo_result_type;

   localparam echo_result_type NO_RESULT = '0;

   typedef enum logic {ROW_BYTE, ROW_MODE} row_kind_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_BEAT} stall_style_type;

   // One row of the directed table; a fixed row carries its result typed in.
   typedef struct {
      row_kind_type    kind;
      logic [7:0]      value;
      logic            is_last;
      logic            fixed;
      echo_result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = 8'h00;   // [7:0] data_byte
   logic        req_tlast   = 1'b0;    // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [63:0] rsp_tdata;             // payload_byte, status, ident, seqno, payload length
   logic [1:0]  rsp_tuser;             // [0] payload_valid, [1] is_reply
   logic        rsp_tlast;             // done_res

   // Parser state as the predictor keeps it.
   logic        v6_mode    = MODE_IPV4;
   logic [15:0] seen_count = '0;
   logic [5:0]  skip_len   = '0;
   logic [15:0] csum       = '0;
   logic [7:0]  high_byte  = '0;
   logic        have_high  = 1'b0;
   logic [7:0]  kind_byte  = '0;
   logic [15:0] ident_acc  = '0;
   logic [15:0] seqno_acc  = '0;

   echo_result_type echo_q[$];
   dir_row_type     dir_rows[$];
   logic [7:0]      pkt_bytes[$];
   echo_result_type row_want  = NO_RESULT;
   logic            row_fixed = 1'b0;
   logic            drive_mode = MODE_IPV4;
   logic            steady = 1'b0;
   int              burst_left = 0;
   int              mismatch_count = 0;
   int              cycle_count = 0;
   stall_style_type stall_style = STALL_NONE;
   int              stall_left = 0;

   icmp_echo_packet_parser_top DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // One's-complement add with the carry wrapped round.
   function automatic logic [15:0] fold16(input logic [15:0] a, input logic [15:0] w);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, w};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   function automatic echo_result_type done_with(input logic [2:0] st);
      echo_result_type r;
      r = NO_RESULT;
      r.done = 1'b1;
      r.status = st;
      return r;
   endfunction

   // Advances the packet state by one byte and returns the result it should give.
   function automatic echo_result_type parse_byte(input logic [7:0] b, input logic is_last);
      echo_result_type r;
      logic [15:0]     off;
      logic [15:0]     total;
      logic [15:0]     icmp_len;
      logic [15:0]     sum;
      r = NO_RESULT;
      if (seen_count == 16'd0) begin
         skip_len = v6_mode ? 6'd0 : {b[3:0], 2'b00};
      end
      if (seen_count >= {10'd0, skip_len}) begin
         off = seen_count - {10'd0, skip_len};
         if (have_high) begin
            csum = fold16(csum, {high_byte, b});
            have_high = 1'b0;
         end else begin
            high_byte = b;
            have_high = 1'b1;
         end
         case (off)
            16'd0: kind_byte = b;
            16'd4: ident_acc[15:8] = b;
            16'd5: ident_acc[7:0] = b;
            16'd6: seqno_acc[15:8] = b;
            16'd7: seqno_acc[7:0] = b;
            default: begin
               if (off >= icmp_ep_pkg::ICMP_HDR_BYTES) begin
                  r.pay_valid = 1'b1;
                  r.pay_byte = b;
               end
            end
         endcase
      end
      total = (seen_count == icmp_ep_pkg::COUNT_MAX) ? icmp_ep_pkg::COUNT_MAX
                                                     : seen_count + 16'd1;
      if (is_last) begin
         sum = have_high ? fold16(csum, {high_byte, 8'h00}) : csum;
         r.done = 1'b1;
         // Checks in order: IP header, ICMP minimum, checksum, type.
         if (total < {10'd0, skip_len}) begin
            r.status = icmp_ep_pkg::ST_SHORT_IP;
         end else begin
            icmp_len = total - {10'd0, skip_len};
            if (icmp_len < icmp_ep_pkg::ICMP_HDR_BYTES) begin
               r.status = icmp_ep_pkg::ST_SHORT_ICMP;
            end else if (!v6_mode && sum != icmp_ep_pkg::SUM_GOOD) begin
               r.status = icmp_ep_pkg::ST_BAD_SUM;
            end else if (kind_byte == (v6_mode ? icmp_ep_pkg::TYPE_V6_REQ
                                               : icmp_ep_pkg::TYPE_V4_REQ)) begin
               r.status = icmp_ep_pkg::ST_OK;
            end else if (kind_byte == (v6_mode ? icmp_ep_pkg::TYPE_V6_REP
                                               : icmp_ep_pkg::TYPE_V4_REP)) begin
               r.status = icmp_ep_pkg::ST_OK;
               r.reply = 1'b1;
            end else begin
               r.status = icmp_ep_pkg::ST_BAD_TYPE;
            end
            if (r.status == icmp_ep_pkg::ST_OK) begin
               r.ident = ident_acc;
               r.seqno = seqno_acc;
               r.pay_len = icmp_len - icmp_ep_pkg::ICMP_HDR_BYTES;
            end
         end
         seen_count = '0;
         skip_len = '0;
         csum = '0;
         high_byte = '0;
         have_high = 1'b0;
         kind_byte = '0;
         ident_acc = '0;
         seqno_acc = '0;
      end else begin
         seen_count = total;
      end
      return r;
   endfunction

   function automatic void report(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         report($sformatf("%s expected 0x%0h, got 0x%0h", name, want, got));
      end
   endfunction

   // Predicts each accepted byte and checks each accepted result against the oldest expectation.
   always @(posedge clock) begin : result_check
      echo_result_type exp_res;
      if (!reset) begin
         if (csr_wr_en) begin
            v6_mode = csr_wr_data;
         end
         if (req_tvalid && req_tready) begin
            exp_res = parse_byte(req_tdata, req_tlast);
            if (row_fixed) begin
               exp_res = row_want;
            end
            echo_q.push_back(exp_res);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (echo_q.size() == 0) begin
               report("result item with nothing expected");
            end else begin
               exp_res = echo_q.pop_front();
               check_field("payload_valid", 16'(exp_res.pay_valid), 16'(rsp_tuser[0]));
               check_field("payload_byte", 16'(exp_res.pay_byte), 16'(rsp_tdata[7:0]));
               check_field("done_res", 16'(exp_res.done), 16'(rsp_tlast));
               check_field("status", 16'(exp_res.status), 16'(rsp_tdata[10:8]));
               check_field("is_reply", 16'(exp_res.reply), 16'(rsp_tuser[1]));
               check_field("ident", exp_res.ident, rsp_tdata[26:11]);
               check_field("seqno", exp_res.seqno, rsp_tdata[42:27]);
               check_field("pay_len", exp_res.pay_len, rsp_tdata[58:43]);
               check_field("tdata padding", 16'd0, 16'(rsp_tdata[63:59]));
            end
         end
      end
   end

   // The receiver switches between never stalling, random stalls and a fixed beat.
   always @(negedge clock) begin
      if (stall_left == 0) begin
         stall_style = stall_style_type'($urandom_range(0, 2));
         stall_left = $urandom_range(32, 400);
      end
      stall_left--;
      case (stall_style)
         STALL_NONE:   rsp_tready <= 1'b1;
         STALL_RANDOM: rsp_tready <= 1'($urandom);
         default:      rsp_tready <= ((cycle_count % 4) == 0);
      endcase
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL");
      $finish;
   end

   // Sends one byte, opening a new burst after a random gap when the last one is used up.
   task automatic send_byte(input logic [7:0] b, input logic is_last, input logic fixed,
                            input echo_result_type want);
      int gap;
      if (burst_left == 0) begin
         gap = steady ? 0 : $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= is_last;
      row_fixed = fixed;
      row_want = want;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_packet();
      for (int i = 0; i < pkt_bytes.size(); i++) begin
         send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, NO_RESULT);
      end
   endtask

   // Holds the sender off until every expected result has come, then lets the block settle.
   task automatic drain_results();
      int waited;
      waited = 0;
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (echo_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (echo_q.size() != 0) begin
         report($sformatf("%0d result items never arrived", echo_q.size()));
         echo_q.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_mode(input logic m);
      drain_results();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= m;
      drive_mode = m;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Builds an echo packet with random content; the checksum is right only when asked.
   task automatic make_echo(input int hdr_words, input logic [7:0] typ, input int pay_count,
                            input logic good_sum);
      logic [7:0]  icmp[$];
      logic [15:0] acc;
      icmp.push_back(typ);
      icmp.push_back(8'($urandom));
      icmp.push_back(8'h00);
      icmp.push_back(8'h00);
      repeat (4 + pay_count) icmp.push_back(8'($urandom));
      acc = '0;
      for (int i = 0; i < icmp.size(); i += 2) begin
         acc = fold16(acc, {icmp[i], (i + 1 < icmp.size()) ? icmp[i + 1] : 8'h00});
      end
      icmp[2] = good_sum ? ~acc[15:8] : 8'($urandom);
      icmp[3] = good_sum ? ~acc[7:0] : 8'($urandom);
      pkt_bytes.delete();
      if (hdr_words > 0) begin
         pkt_bytes.push_back({4'($urandom), 4'(hdr_words)});
         repeat (4 * hdr_words - 1) pkt_bytes.push_back(8'($urandom));
      end
      foreach (icmp[i]) pkt_bytes.push_back(icmp[i]);
   endtask

   initial begin : stimulus
      int          random_items;
      int          pkts_in_phase;
      int          pick;
      int          cut;
      int          hdr_words;
      int          pay_count;
      logic [7:0]  typ;

      // Directed table, in IPv4 mode after reset.
      // One byte whose header length exceeds the packet.
      dir_rows.push_back('{ROW_BYTE, 8'h4F, 1'b1, 1'b1, done_with(icmp_ep_pkg::ST_SHORT_IP)});
      // Header length of zero, ICMP part far too short.
      dir_rows.push_back('{ROW_BYTE, 8'h40, 1'b0, 1'b1, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'hFF, 1'b1, 1'b1,
                           done_with(icmp_ep_pkg::ST_SHORT_ICMP)});
      // Echo reply with no IP header, odd length so the final byte is padded.
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'hEC, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h52, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h12, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h34, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h56, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h78, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'hAB, 1'b1, 1'b0, NO_RESULT});
      // Minimum-length echo reply with a wrong checksum.
      repeat (7) dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b1, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h01, 1'b1, 1'b1, done_with(icmp_ep_pkg::ST_BAD_SUM)});
      // IPv6 echo reply: no header skip and the checksum bytes are ignored.
      dir_rows.push_back('{ROW_MODE, {7'd0, MODE_IPV6}, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h81, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'hFF, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b0, 1'b0, NO_RESULT});
      dir_rows.push_back('{ROW_BYTE, 8'h00, 1'b1, 1'b0, NO_RESULT});

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         if (dir_rows[i].kind == ROW_MODE) begin
            write_mode(dir_rows[i].value[0]);
         end else begin
            send_byte(dir_rows[i].value, dir_rows[i].is_last, dir_rows[i].fixed,
                      dir_rows[i].want);
         end
      end

      // Random packets: mostly well-formed echoes, the rest cut short or plain noise.
      write_mode(MODE_IPV4);
      random_items = 0;
      pkts_in_phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         if (pkts_in_phase == 6) begin
            write_mode(1'($urandom));
            pkts_in_phase = 0;
         end
         pkts_in_phase++;
         steady = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 85) begin
            hdr_words = 0;
            if (drive_mode == MODE_IPV4) begin
               hdr_words = ($urandom_range(0, 4) != 0) ? 5 : $urandom_range(0, 15);
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: typ = (drive_mode == MODE_IPV6) ? icmp_ep_pkg::TYPE_V6_REQ
                                                              : icmp_ep_pkg::TYPE_V4_REQ;
               5, 6, 7, 8:    typ = (drive_mode == MODE_IPV6) ? icmp_ep_pkg::TYPE_V6_REP
                                                              : icmp_ep_pkg::TYPE_V4_REP;
               default:       typ = 8'($urandom);
            endcase
            pay_count = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 20)
                                                   : $urandom_range(21, 100);
            make_echo(hdr_words, typ, pay_count, $urandom_range(0, 9) != 0);
            // Some well-formed packets are cut off at a random byte.
            if (pick >= 70) begin
               cut = $urandom_range(1, pkt_bytes.size());
               while (pkt_bytes.size() > cut) void'(pkt_bytes.pop_back());
            end
         end else begin
            pkt_bytes.delete();
            repeat ($urandom_range(1, 40)) pkt_bytes.push_back(8'($urandom));
         end
         send_packet();
         random_items += pkt_bytes.size();
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
